// ===== design/sms_notice_byte_parser_defines.svh =====
// Assertion macros used by the parser's top-level RTL.
`ifndef SMS_NOTICE_BYTE_PARSER_DEFINES_SVH
`define SMS_NOTICE_BYTE_PARSER_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define SNBP_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("sms parser check failed");

// Condition a implies condition b in the next cycle.
`define SNBP_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("sms parser check failed");

// Condition c holds at every clock edge out of reset.
`define SNBP_ASSERT_ALWAYS(label, c) \
  label: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("sms parser check failed");

`endif

// ===== design/snbp_pkg.sv =====
`default_nettype none
package snbp_pkg;

  localparam int PHONE_LEN  = 13;
  localparam int TEXT_DEPTH = 16;

  localparam int PHONE_CW = $clog2(PHONE_LEN + 1);
  localparam int PHONE_AW = $clog2(PHONE_LEN);
  localparam int TEXT_CW  = $clog2(TEXT_DEPTH + 1);
  localparam int TEXT_AW  = $clog2(TEXT_DEPTH);

  localparam int STRIP_W = 3;

  localparam logic [7:0]         QUOTE_BYTE   = 8'h22;
  localparam logic [7:0]         LF_BYTE      = 8'h0A;
  localparam logic [STRIP_W-1:0] PREFIX_RESET = 3'd3;

  // controller -> datapath
  typedef struct packed {
    logic phone_clear;
    logic phone_write;
    logic text_clear;
    logic text_write;
    logic overflow_set;
    logic finish;
    logic drain_step;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_quote;
    logic is_lf;
    logic phone_full;
    logic text_full;
    logic run_empty;
    logic slot_free;
    logic drain_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/snbp_ctrl.sv =====
`default_nettype none
module snbp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire snbp_pkg::dp_status_t sts,
  output snbp_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_WAIT_QUOTE = 5'b00001,
    ST_PHONE      = 5'b00010,
    ST_WAIT_LF    = 5'b00100,
    ST_TEXT       = 5'b01000,
    ST_DRAIN      = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  assign in_ready = (state != ST_DRAIN);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_WAIT_QUOTE: begin
        if (in_fire && sts.is_quote) begin
          cmd.phone_clear = 1'b1;
          state_next      = ST_PHONE;
        end
      end
      ST_PHONE: begin
        if (in_fire) begin
          if (!sts.phone_full) begin
            cmd.phone_write = 1'b1;
          end else begin
            state_next = ST_WAIT_LF;  // byte after the number is skipped
          end
        end
      end
      ST_WAIT_LF: begin
        if (in_fire && sts.is_lf) begin
          cmd.text_clear = 1'b1;
          state_next     = ST_TEXT;
        end
      end
      ST_TEXT: begin
        if (in_fire) begin
          if (sts.is_lf) begin
            cmd.finish = 1'b1;
            state_next = sts.run_empty ? ST_WAIT_QUOTE : ST_DRAIN;
          end else if (!sts.text_full) begin
            cmd.text_write = 1'b1;
          end else begin
            cmd.overflow_set = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (sts.slot_free) begin
          cmd.drain_step = 1'b1;
          if (sts.drain_last) begin
            state_next = ST_WAIT_QUOTE;
          end
        end
      end
      default: begin
        state_next = ST_WAIT_QUOTE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT_QUOTE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/snbp_dp.sv =====
`default_nettype none
module snbp_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [snbp_pkg::STRIP_W-1:0] cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        char_value,
  output logic                              is_message,
  output logic                              truncated,
  output logic                              last,
  input  wire snbp_pkg::ctrl_cmd_t          cmd,
  output snbp_pkg::dp_status_t              sts
);

  localparam int PCW = snbp_pkg::PHONE_CW;
  localparam int PAW = snbp_pkg::PHONE_AW;
  localparam int TCW = snbp_pkg::TEXT_CW;
  localparam int TAW = snbp_pkg::TEXT_AW;

  localparam logic [PCW-1:0] PHONE_END  = PCW'(snbp_pkg::PHONE_LEN);
  localparam logic [PCW-1:0] PHONE_LAST = PCW'(snbp_pkg::PHONE_LEN - 1);
  localparam logic [TCW-1:0] TEXT_END   = TCW'(snbp_pkg::TEXT_DEPTH);

  logic [snbp_pkg::STRIP_W-1:0] prefix_strip;
  logic [PCW-1:0]               phone_count;
  logic [7:0]                   phone_store [snbp_pkg::PHONE_LEN];
  logic [TCW-1:0]               text_count;
  logic [7:0]                   text_store [snbp_pkg::TEXT_DEPTH];
  logic                         overflowed;
  logic [PCW-1:0]               rd_phone;
  logic [TCW-1:0]               rd_text;

  logic [PCW-1:0] strip_ext;
  logic [PCW-1:0] strip_start;
  logic           in_phone_part;
  logic [7:0]     rd_char;

  assign cfg_ready = 1'b1;

  assign strip_ext   = PCW'(prefix_strip);
  assign strip_start = (strip_ext > PHONE_END) ? PHONE_END : strip_ext;

  assign in_phone_part = (rd_phone < PHONE_END);
  assign rd_char = in_phone_part ? phone_store[rd_phone[PAW-1:0]]
                                 : text_store[rd_text[TAW-1:0]];

  always_comb begin
    sts.is_quote   = (rx_byte == snbp_pkg::QUOTE_BYTE);
    sts.is_lf      = (rx_byte == snbp_pkg::LF_BYTE);
    sts.phone_full = (phone_count >= PHONE_END);
    sts.text_full  = (text_count >= TEXT_END);
    // run is empty once the byte before the line feed is dropped
    sts.run_empty  = (strip_start == PHONE_END) && (text_count <= TCW'(1));
    sts.slot_free  = !out_valid || out_ready;
    if (in_phone_part) begin
      sts.drain_last = (rd_phone == PHONE_LAST) && (text_count == '0);
    end else begin
      sts.drain_last = (rd_text == text_count - TCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_strip <= snbp_pkg::PREFIX_RESET;
      phone_count  <= '0;
      text_count   <= '0;
      overflowed   <= 1'b0;
      out_valid    <= 1'b0;
      rd_phone     <= '0;
      rd_text      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        prefix_strip <= cfg_data;
      end
      if (cmd.phone_clear) begin
        phone_count <= '0;
      end else if (cmd.phone_write) begin
        phone_count <= phone_count + PCW'(1);
      end
      if (cmd.text_clear) begin
        text_count <= '0;
        overflowed <= 1'b0;
      end else if (cmd.text_write) begin
        text_count <= text_count + TCW'(1);
      end else if (cmd.overflow_set) begin
        overflowed <= 1'b1;
      end else if (cmd.finish) begin
        if (text_count != '0) begin
          text_count <= text_count - TCW'(1);
        end
        rd_phone <= strip_start;
        rd_text  <= '0;
      end
      if (cmd.drain_step) begin
        out_valid <= 1'b1;
        if (in_phone_part) begin
          rd_phone <= rd_phone + PCW'(1);
        end else begin
          rd_text <= rd_text + TCW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phone_write) begin
      phone_store[phone_count[PAW-1:0]] <= rx_byte;
    end
    if (cmd.text_write) begin
      text_store[text_count[TAW-1:0]] <= rx_byte;
    end
    if (cmd.drain_step) begin
      char_value <= rd_char;
      is_message <= !in_phone_part;
      truncated  <= overflowed;
      last       <= sts.drain_last;
    end
  end

endmodule
`default_nettype wire

// ===== design/sms_notice_byte_parser.sv =====
// Channel   | Handshake             | Payload
// ----------+-----------------------+----------------------------------------
// input     | in_valid / in_ready   | rx_byte[7:0]
// output    | out_valid / out_ready | char_value[7:0], is_message, truncated,
//           |                       | last
// config    | cfg_valid / cfg_ready | cfg_data[2:0] (prefix_strip)
//
// Flow: a byte is taken whenever in_ready is high. The closing line feed starts
//   a drain that emits one item per cycle through the output register unless
//   out_ready is low, up to PHONE_LEN + TEXT_DEPTH - 1 items; in_ready is low for the drain.
// Reset: rst is synchronous, active high; clears phase, counters, the
//   overflow flag and the output valid. prefix_strip returns to 3.
// Stalls: out_ready low holds the drain; bytes are taken again once the last
//   item is loaded, even while it still waits in the output register.
`default_nettype none
`include "sms_notice_byte_parser_defines.svh"
module sms_notice_byte_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // received byte stream
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   rx_byte,
  // configuration write
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [snbp_pkg::STRIP_W-1:0] cfg_data,
  // notice run
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        char_value,
  output logic                              is_message,
  output logic                              truncated,
  output logic                              last
);

  snbp_pkg::ctrl_cmd_t  cmd;
  snbp_pkg::dp_status_t sts;

  // Sequencer: parse phase (quote, phone, line feed, text) plus the drain.
  snbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Stores, counters, prefix register and the output register.
  snbp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_value (char_value),
    .is_message (is_message),
    .truncated  (truncated),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts)
  );

  // no byte is taken while the run is draining
  `SNBP_ASSERT_SAME(a_no_take_in_drain, cmd.drain_step, !in_ready)
  // after the final item is loaded the parser takes bytes again
  `SNBP_ASSERT_NEXT(a_ready_after_last, cmd.drain_step && sts.drain_last, in_ready)
  // at most one store, counter or drain action in any cycle
  `SNBP_ASSERT_ALWAYS(a_one_action, $onehot0({cmd.phone_clear, cmd.phone_write,
    cmd.text_clear, cmd.text_write, cmd.overflow_set, cmd.finish, cmd.drain_step}))

endmodule
`default_nettype wire
